>>> rtl/number_theoretic_transform_defines.svh
// Assertion macros shared by the transform RTL.
// Used by ntt_mulmod and number_theoretic_transform; expects clk and rst in scope.
`ifndef NUMBER_THEORETIC_TRANSFORM_DEFINES_SVH
`define NUMBER_THEORETIC_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define NTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ntt_pkg.sv
// Shared types and constants for the number theoretic transform.
// No dependencies; imported by ntt_mulmod and number_theoretic_transform.
`default_nettype none
package ntt_pkg;

  localparam int VAL_W = 31;
  localparam int POS_W = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [VAL_W-1:0] MODULUS_RST = 31'd998244353;
  localparam logic [VAL_W-1:0] BASE_ROOT_RST = 31'd31;
  localparam logic [4:0] TWO_ADICITY_RST = 5'd23;
  localparam logic [2:0] LOG_LENGTH_RST = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS     = 3'd0,
    CFG_BASE_ROOT   = 3'd1,
    CFG_TWO_ADICITY = 3'd2,
    CFG_LOG_LENGTH  = 3'd3,
    CFG_INVERSE     = 3'd4
  } cfg_idx_t;

  // request to the modular multiplier: result = a * b mod m, a must be below m
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } mm_res_t;

endpackage
`default_nettype wire

>>> rtl/ntt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module ntt_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/ntt_mulmod.sv
// Bit-serial modular multiplier, one bit of b per cycle (double, then add).
// Depends on ntt_pkg and the assertion macros header.
`default_nettype none
`include "number_theoretic_transform_defines.svh"
module ntt_mulmod (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ntt_pkg::mm_req_t req,
  output ntt_pkg::mm_res_t     res
);
  import ntt_pkg::*;

  logic [VAL_W-1:0] a_q;
  logic [VAL_W-1:0] b_q;
  logic [VAL_W-1:0] m_q;
  logic [VAL_W-1:0] acc;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [VAL_W:0]   dbl;
  logic [VAL_W:0]   dbl_red;
  logic [VAL_W:0]   sum;
  logic [VAL_W:0]   sum_red;

  // acc stays below m, so each step needs one compare-subtract per add
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum     = dbl_red + (b_q[VAL_W-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(VAL_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q <= req.a;
      b_q <= req.b;
      m_q <= req.m;
      acc <= '0;
    end else if (busy) begin
      acc <= sum_red[VAL_W-1:0];
      b_q <= {b_q[VAL_W-2:0], 1'b0};
    end
  end

  assign res.done  = done;
  assign res.value = acc;

  `NTT_ASSERT_NOW(a_mm_no_restart, req.start, !busy, "multiplier restarted while busy")
  `NTT_ASSERT_NOW(a_mm_reduced, done, acc < m_q || m_q == '0, "product not reduced")
  `NTT_ASSERT_NXT(a_mm_done_pulse, done, !done, "done held for more than one cycle")

endmodule
`default_nettype wire

>>> rtl/number_theoretic_transform.sv
// Radix-2 NTT: load, reduce, reorder, twiddle build, butterflies, scale, output.
// Depends on ntt_pkg, ntt_ram, ntt_mulmod and the assertion macros header.
// Every modular multiply goes through the shared bit-serial unit. Each loaded item
// is reduced by one multiply before the next is taken. The transform of n = 2^lg runs
// a reduce pass over all n items, a bit-reverse reorder (preceded by an index reversal
// for the inverse), the twiddle multiplies, one multiply per butterfly ((n/2)*lg of them)
// and a scale pass when inverse, then one result at a time while the output is ready.
// Reset: configuration to defaults, state, idx, load_cnt, s and out_valid cleared; RAMs not cleared.
`default_nettype none
`include "number_theoretic_transform_defines.svh"
module number_theoretic_transform #(
  parameter int MAX_LOG_LENGTH = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ntt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ntt_pkg::VAL_W-1:0]     cfg_data,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,   // [30:0] coefficient
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,   // [30:0] value, [36:31] position
  output logic                               m_axis_tlast    // final_res
);
  import ntt_pkg::*;

  localparam int AW = MAX_LOG_LENGTH;
  localparam int CW = AW + 1;
  localparam int SW = $clog2(MAX_LOG_LENGTH + 2);
  localparam int DEPTH = 1 << AW;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LRED  = 16'h0002,
    S_DISP  = 16'h0004,
    S_RDA   = 16'h0008,
    S_RDB   = 16'h0010,
    S_RDC   = 16'h0020,
    S_MUL   = 16'h0040,
    S_WRA   = 16'h0080,
    S_WRB   = 16'h0100,
    S_TB    = 16'h0200,
    S_TBW   = 16'h0400,
    S_TSQ   = 16'h0800,
    S_TSQW  = 16'h1000,
    S_TCH   = 16'h2000,
    S_TCHW  = 16'h4000,
    S_OCAP  = 16'h8000
  } state_t;

  typedef enum logic [7:0] {
    P_REDUCE  = 8'h01,
    P_REVERSE = 8'h02,
    P_BITREV  = 8'h04,
    P_TWID    = 8'h08,
    P_BFLY    = 8'h10,
    P_SCALE   = 8'h20,
    P_OUT     = 8'h40,
    P_ORD     = 8'h80
  } phase_t;

  // configuration
  logic [VAL_W-1:0] modulus;
  logic [VAL_W-1:0] base_root;
  logic [4:0]       two_adicity;
  logic [2:0]       log_length;
  logic             inverse_mode;

  state_t           state;
  phase_t           phase;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    load_cnt;
  logic [SW-1:0]    s;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [AW-1:0]    tw_addr;
  logic [VAL_W-1:0] ua;
  logic [VAL_W-1:0] twd;
  logic [VAL_W-1:0] va;
  logic [VAL_W-1:0] vb;
  logic [VAL_W-1:0] wreg;
  logic [VAL_W-1:0] prev;
  logic [4:0]       sqcnt;
  logic [AW-1:0]    tj;

  logic [VAL_W-1:0] out_value;
  logic [POS_W-1:0] out_pos;
  logic             out_last;
  logic             out_valid;

  // derived values
  logic [SW-1:0]    lg;
  logic [CW-1:0]    n;
  logic [CW-1:0]    half;
  logic [VAL_W-1:0] m;
  logic [VAL_W-1:0] one_m;
  logic [VAL_W-1:0] sc;
  logic [VAL_W:0]   sc_t;
  logic [AW-1:0]    h;
  logic [AW-1:0]    bf_j;
  logic [AW-1:0]    bf_a;
  logic [AW-1:0]    rev_full;
  logic [AW-1:0]    br;
  logic [CW-1:0]    rv_j;
  logic [4:0]       sq_init;
  logic [VAL_W:0]   bsum;
  logic [VAL_W:0]   bsum_red;
  logic [VAL_W:0]   bdiff;
  logic             single;
  logic             out_load;

  // RAM ports
  logic             c_we;
  logic [AW-1:0]    c_waddr;
  logic [VAL_W-1:0] c_wdata;
  logic [AW-1:0]    c_raddr;
  logic [VAL_W-1:0] c_rdata;
  logic             t_we;
  logic [AW-1:0]    t_waddr;
  logic [VAL_W-1:0] t_wdata;
  logic [VAL_W-1:0] t_rdata;

  mm_req_t          mm_req;
  mm_res_t          mm_res;

  always_comb begin
    if (int'(log_length) > MAX_LOG_LENGTH) begin
      lg = SW'(MAX_LOG_LENGTH);
    end else begin
      lg = SW'(log_length);
    end
    n     = CW'(1) << lg;
    half  = n >> 1;
    m     = (modulus == '0) ? VAL_W'(1) : modulus;
    one_m = (m == VAL_W'(1)) ? '0 : VAL_W'(1);
    // n^-1 in the usual case; zero when it wraps to m
    sc_t  = {1'b0, m} - (({1'b0, m} - (VAL_W+1)'(1)) >> lg);
    sc    = (sc_t == {1'b0, m}) ? '0 : sc_t[VAL_W-1:0];
    h     = AW'(CW'(1) << (s - SW'(1)));
    bf_j  = idx[AW-1:0] & (h - AW'(1));
    bf_a  = AW'({idx[AW-1:0] & ~(h - AW'(1)), 1'b0}) | bf_j;
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = idx[AW-1-b];
    end
    br    = rev_full >> (AW - int'(lg));
    rv_j  = n - idx;
    if (int'(two_adicity) > int'(s)) begin
      sq_init = 5'(int'(two_adicity) - int'(s));
    end else begin
      sq_init = '0;
    end
    bsum     = {1'b0, ua} + {1'b0, mm_res.value};
    bsum_red = (bsum >= {1'b0, m}) ? bsum - {1'b0, m} : bsum;
    bdiff    = (ua >= mm_res.value) ? {1'b0, ua} - {1'b0, mm_res.value}
                                    : {1'b0, ua} + {1'b0, m} - {1'b0, mm_res.value};
    single   = (phase == P_REDUCE) || (phase == P_SCALE);
    out_load = (state == S_OCAP) && (!out_valid || m_axis_tready);
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_pos, out_value};
  assign m_axis_tlast  = out_last;

  // multiplier requests
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.a     = one_m;
    mm_req.b     = s_axis_tdata[VAL_W-1:0];
    mm_req.m     = m;
    unique case (state)
      S_IDLE: begin
        mm_req.start = s_axis_tvalid;
      end
      S_RDB: begin
        if (phase == P_REDUCE) begin
          mm_req.start = 1'b1;
          mm_req.b     = c_rdata;
        end else if (phase == P_SCALE) begin
          mm_req.start = 1'b1;
          mm_req.a     = c_rdata;
          mm_req.b     = sc;
        end
      end
      S_RDC: begin
        if (phase == P_BFLY) begin
          mm_req.start = 1'b1;
          mm_req.a     = c_rdata;
          mm_req.b     = twd;
        end
      end
      S_TB: begin
        mm_req.start = 1'b1;
        mm_req.b     = base_root;
      end
      S_TSQ: begin
        mm_req.start = (sqcnt != '0);
        mm_req.a     = wreg;
        mm_req.b     = wreg;
      end
      S_TCH: begin
        mm_req.start = (tj < h);
        mm_req.a     = prev;
        mm_req.b     = wreg;
      end
      default: begin
      end
    endcase
  end

  // RAM control
  always_comb begin
    c_we    = 1'b0;
    c_waddr = addr_a;
    c_wdata = va;
    c_raddr = addr_a;
    t_we    = 1'b0;
    t_waddr = h | tj;
    t_wdata = mm_res.value;
    unique case (state)
      S_LRED: begin
        c_we    = mm_res.done;
        c_waddr = load_cnt[AW-1:0];
        c_wdata = mm_res.value;
      end
      S_WRA: begin
        c_we = 1'b1;
      end
      S_WRB: begin
        c_we    = 1'b1;
        c_waddr = addr_b;
        c_wdata = vb;
      end
      S_RDB: begin
        c_raddr = addr_b;
      end
      S_OCAP: begin
        c_raddr = idx[AW-1:0];
      end
      S_DISP: begin
        c_raddr = idx[AW-1:0];
      end
      S_TSQ: begin
        t_we    = (sqcnt == '0);
        t_waddr = h;
        t_wdata = one_m;
      end
      S_TCHW: begin
        t_we = mm_res.done;
      end
      default: begin
      end
    endcase
  end

  ntt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_coeff_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  ntt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_twiddle_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (tw_addr),
    .rdata (t_rdata)
  );

  ntt_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .res (mm_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= MODULUS_RST;
      base_root    <= BASE_ROOT_RST;
      two_adicity  <= TWO_ADICITY_RST;
      log_length   <= LOG_LENGTH_RST;
      inverse_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus      <= cfg_data;
        CFG_BASE_ROOT:   base_root    <= cfg_data;
        CFG_TWO_ADICITY: two_adicity  <= cfg_data[4:0];
        CFG_LOG_LENGTH:  log_length   <= cfg_data[2:0];
        CFG_INVERSE:     inverse_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_REDUCE;
      idx       <= '0;
      load_cnt  <= '0;
      s         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_LRED;
          end
        end
        S_LRED: begin
          if (mm_res.done) begin
            if (load_cnt + CW'(1) >= n) begin
              load_cnt <= '0;
              phase    <= P_REDUCE;
              idx      <= '0;
              state    <= S_DISP;
            end else begin
              load_cnt <= load_cnt + CW'(1);
              state    <= S_IDLE;
            end
          end
        end
        S_DISP: begin
          unique case (phase) inside
            P_REDUCE, P_SCALE: begin
              if (idx < n) begin
                addr_a <= idx[AW-1:0];
                state  <= S_RDA;
              end else if (phase == P_REDUCE) begin
                phase <= inverse_mode ? P_REVERSE : P_BITREV;
                idx   <= inverse_mode ? CW'(1) : '0;
              end else begin
                phase <= P_OUT;
                idx   <= '0;
              end
            end
            P_REVERSE: begin
              if (idx < rv_j) begin
                addr_a <= idx[AW-1:0];
                addr_b <= rv_j[AW-1:0];
                state  <= S_RDA;
              end else begin
                phase <= P_BITREV;
                idx   <= '0;
              end
            end
            P_BITREV: begin
              if (idx < n) begin
                if ({1'b0, br} > idx) begin
                  addr_a <= idx[AW-1:0];
                  addr_b <= br;
                  state  <= S_RDA;
                end else begin
                  idx <= idx + CW'(1);
                end
              end else begin
                phase <= P_TWID;
                s     <= SW'(1);
              end
            end
            P_TWID: begin
              if (s > lg) begin
                phase <= P_BFLY;
                s     <= SW'(1);
                idx   <= '0;
              end else begin
                state <= S_TB;
              end
            end
            P_BFLY: begin
              if (s > lg) begin
                phase <= inverse_mode ? P_SCALE : P_OUT;
                idx   <= '0;
              end else if (idx < half) begin
                addr_a  <= bf_a;
                addr_b  <= bf_a | h;
                tw_addr <= h | bf_j;
                state   <= S_RDA;
              end else begin
                s   <= s + SW'(1);
                idx <= '0;
              end
            end
            P_OUT: begin
              if (idx < n) begin
                phase <= P_ORD;
              end else begin
                state <= S_IDLE;
              end
            end
            P_ORD: begin
              // read of idx issued this cycle
              state <= S_OCAP;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          ua    <= c_rdata;
          twd   <= t_rdata;
          state <= single ? S_MUL : S_RDC;
        end
        S_RDC: begin
          if (phase == P_BFLY) begin
            state <= S_MUL;
          end else begin
            va    <= c_rdata;
            vb    <= ua;
            state <= S_WRA;
          end
        end
        S_MUL: begin
          if (mm_res.done) begin
            if (single) begin
              va <= mm_res.value;
            end else begin
              va <= bsum_red[VAL_W-1:0];
              vb <= bdiff[VAL_W-1:0];
            end
            state <= S_WRA;
          end
        end
        S_WRA: begin
          if (single) begin
            idx   <= idx + CW'(1);
            state <= S_DISP;
          end else begin
            state <= S_WRB;
          end
        end
        S_WRB: begin
          idx   <= idx + CW'(1);
          state <= S_DISP;
        end
        S_TB: begin
          state <= S_TBW;
        end
        S_TBW: begin
          if (mm_res.done) begin
            wreg  <= mm_res.value;
            sqcnt <= sq_init;
            state <= S_TSQ;
          end
        end
        S_TSQ: begin
          if (sqcnt != '0) begin
            state <= S_TSQW;
          end else begin
            prev  <= one_m;
            tj    <= AW'(1);
            state <= S_TCH;
          end
        end
        S_TSQW: begin
          if (mm_res.done) begin
            wreg  <= mm_res.value;
            sqcnt <= sqcnt - 5'd1;
            state <= S_TSQ;
          end
        end
        S_TCH: begin
          if (tj < h) begin
            state <= S_TCHW;
          end else begin
            s     <= s + SW'(1);
            state <= S_DISP;
          end
        end
        S_TCHW: begin
          if (mm_res.done) begin
            prev  <= mm_res.value;
            tj    <= tj + AW'(1);
            state <= S_TCH;
          end
        end
        S_OCAP: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_value <= c_rdata;
            out_pos   <= POS_W'(idx);
            out_last  <= (idx == n - CW'(1));
            idx       <= idx + CW'(1);
            phase     <= P_OUT;
            state     <= S_DISP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NTT_ASSERT_NOW(a_done_expected, mm_res.done,
    state == S_LRED || state == S_MUL || state == S_TBW || state == S_TSQW ||
    state == S_TCHW, "multiplier result with no step waiting")
  `NTT_ASSERT_NXT(a_load_starts, s_axis_tvalid && s_axis_tready, state == S_LRED,
    "accepted item not reduced")
  `NTT_ASSERT_NOW(a_pair_distinct, state == S_WRB, addr_a != addr_b,
    "pair write to one entry")

endmodule
`default_nettype wire
